@@ src/tdd_pkg.sv @@
package tdd_pkg;

  localparam int unsigned AccelW    = 13;
  localparam int unsigned BandW     = 12;
  localparam int unsigned CountW    = 16;
  localparam int unsigned RegIdxW   = 2;
  localparam int unsigned ApbAddrW  = 4;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;

  typedef enum logic [2:0] {
    DIR_NONE   = 3'd0,
    DIR_X_UP   = 3'd1,
    DIR_X_DOWN = 3'd2,
    DIR_Y_UP   = 3'd3,
    DIR_Y_DOWN = 3'd4,
    DIR_Z_UP   = 3'd5,
    DIR_Z_DOWN = 3'd6
  } tdd_dir_e;

  // register indexes, byte address is 4 times the index
  localparam logic [RegIdxW-1:0] REG_DEAD_BAND    = 2'd0;
  localparam logic [RegIdxW-1:0] REG_UPPER_LIMIT  = 2'd1;
  localparam logic [RegIdxW-1:0] REG_LOWER_LIMIT  = 2'd2;
  localparam logic [RegIdxW-1:0] REG_SETTLE_COUNT = 2'd3;

  localparam logic [BandW-1:0]         DeadBandRst    = 12'd5;
  localparam logic [BandW-1:0]         UpperLimitRst  = 12'd10;
  localparam logic signed [AccelW-1:0] LowerLimitRst  = -13'sd10;
  localparam logic [CountW-1:0]        SettleCountRst = 16'd256;

  typedef struct packed {
    logic [BandW-1:0]         dead_band;
    logic [BandW-1:0]         upper_limit;
    logic signed [AccelW-1:0] lower_limit;
    logic [CountW-1:0]        settle_count;
  } tdd_cfg_t;

endpackage

@@ src/tilt_direction_detector.sv @@
// Tilt direction detector: each sample transaction on the slave stream carries one
// signed 13-bit x, y and z reading and yields exactly one result transaction with a
// 3-bit direction code (0 none, 1/2 x up/down, 3/4 y up/down, 5/6 z up/down). A code
// other than none appears only when a new direction has settled, that is once more
// than settle_count classified samples differing from the committed direction have
// been seen. The block takes one sample per cycle while the master side is ready: a
// sample is held in an input register, classified combinationally and counted as it
// passes on, and its result sits in an output register. Thresholds and the settle
// count are to be written over the APB port only while the stream is idle; the block
// itself does not enforce this. Reset values are dead band 5, limits +10 and -10, count 256.
module tilt_direction_detector import tdd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]   prdata,
  output logic                  pready,
  // sample stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [InDataW-1:0]    s_axis_tdata,  // accel_x[12:0], accel_y[25:13], accel_z[38:26]
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OutDataW-1:0]   m_axis_tdata   // new_direction[2:0]
);

  tdd_cfg_t cfg_q;
  logic     cfg_wr;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_band    <= DeadBandRst;
      cfg_q.upper_limit  <= UpperLimitRst;
      cfg_q.lower_limit  <= LowerLimitRst;
      cfg_q.settle_count <= SettleCountRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEAD_BAND:    cfg_q.dead_band    <= pwdata[BandW-1:0];
        REG_UPPER_LIMIT:  cfg_q.upper_limit  <= pwdata[BandW-1:0];
        REG_LOWER_LIMIT:  cfg_q.lower_limit  <= $signed(pwdata[AccelW-1:0]);
        REG_SETTLE_COUNT: cfg_q.settle_count <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEAD_BAND:    prdata = {{(ApbDataW-BandW){1'b0}}, cfg_q.dead_band};
      REG_UPPER_LIMIT:  prdata = {{(ApbDataW-BandW){1'b0}}, cfg_q.upper_limit};
      REG_LOWER_LIMIT:  prdata = {{(ApbDataW-AccelW){cfg_q.lower_limit[AccelW-1]}},
                                  cfg_q.lower_limit};
      REG_SETTLE_COUNT: prdata = {{(ApbDataW-CountW){1'b0}}, cfg_q.settle_count};
      default:          prdata = '0;
    endcase
  end

  // input register
  logic                     in_valid_q;
  logic signed [AccelW-1:0] x_q, y_q, z_q;
  logic                     advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      x_q <= $signed(s_axis_tdata[AccelW-1:0]);
      y_q <= $signed(s_axis_tdata[2*AccelW-1:AccelW]);
      z_q <= $signed(s_axis_tdata[3*AccelW-1:2*AccelW]);
    end
  end

  tdd_dir_e dir;
  tdd_dir_e result;
  tdd_dir_e committed;

  tdd_classify u_classify (
    .cfg_i     (cfg_q),
    .accel_x_i (x_q),
    .accel_y_i (y_q),
    .accel_z_i (z_q),
    .dir_o     (dir)
  );

  tdd_settle u_settle (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .dir_i          (dir),
    .settle_count_i (cfg_q.settle_count),
    .result_o       (result),
    .committed_o    (committed)
  );

  // result register
  logic     out_valid_q;
  tdd_dir_e out_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_dir_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, out_dir_q};

  // a reported direction is always the one now committed
  a_report_committed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_dir_q != DIR_NONE)) |-> (out_dir_q == committed))
    else $error("reported direction differs from committed direction");

  // back pressure only while a sample is held
  a_stall_needs_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input stalled with empty input register");

  // the committed direction only moves when a sample passes through
  a_commit_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(committed))
    else $error("committed direction changed without a sample");

  // a committed change is always reported
  a_commit_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (result != DIR_NONE)) |=> (out_valid_q && (out_dir_q == committed)))
    else $error("commit not reported");

endmodule

@@ src/tdd_classify.sv @@
module tdd_classify import tdd_pkg::*; (
  input  tdd_cfg_t                 cfg_i,
  input  logic signed [AccelW-1:0] accel_x_i,
  input  logic signed [AccelW-1:0] accel_y_i,
  input  logic signed [AccelW-1:0] accel_z_i,
  output tdd_dir_e                 dir_o
);

  // one extra bit so that the negated band and the limits fit
  logic signed [AccelW:0] band_hi;
  logic signed [AccelW:0] band_lo;
  logic signed [AccelW:0] up_lim;
  logic signed [AccelW:0] lo_lim;
  logic signed [AccelW:0] x_ext;
  logic signed [AccelW:0] y_ext;
  logic signed [AccelW:0] z_ext;
  logic x_near, y_near, z_near;

  assign band_hi = $signed({2'b00, cfg_i.dead_band});
  assign band_lo = -band_hi;
  assign up_lim  = $signed({2'b00, cfg_i.upper_limit});
  assign lo_lim  = {cfg_i.lower_limit[AccelW-1], cfg_i.lower_limit};
  assign x_ext   = {accel_x_i[AccelW-1], accel_x_i};
  assign y_ext   = {accel_y_i[AccelW-1], accel_y_i};
  assign z_ext   = {accel_z_i[AccelW-1], accel_z_i};

  assign x_near = (x_ext >= band_lo) && (x_ext <= band_hi);
  assign y_near = (y_ext >= band_lo) && (y_ext <= band_hi);
  assign z_near = (z_ext >= band_lo) && (z_ext <= band_hi);

  always_comb begin
    dir_o = DIR_NONE;
    if (z_near) begin
      if (y_near && (x_ext > up_lim)) begin
        dir_o = DIR_X_UP;
      end else if (y_near && (x_ext < lo_lim)) begin
        dir_o = DIR_X_DOWN;
      end else if (x_near && (y_ext > up_lim)) begin
        dir_o = DIR_Y_UP;
      end else if (x_near && (y_ext < lo_lim)) begin
        dir_o = DIR_Y_DOWN;
      end
    end else if (x_near && y_near) begin
      if (z_ext > up_lim) begin
        dir_o = DIR_Z_UP;
      end else if (z_ext < lo_lim) begin
        dir_o = DIR_Z_DOWN;
      end
    end
  end

endmodule

@@ src/tdd_settle.sv @@
module tdd_settle import tdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tdd_dir_e          dir_i,
  input  logic [CountW-1:0] settle_count_i,
  output tdd_dir_e          result_o,
  output tdd_dir_e          committed_o
);

  tdd_dir_e          committed_q, committed_d;
  logic [CountW-1:0] counter_q, counter_d;

  always_comb begin
    committed_d = committed_q;
    counter_d   = counter_q;
    result_o    = DIR_NONE;
    if (en_i && (dir_i != DIR_NONE) && (dir_i != committed_q)) begin
      if (counter_q > settle_count_i) begin
        committed_d = dir_i;
        counter_d   = '0;
        result_o    = dir_i;
      end else if (counter_q != {CountW{1'b1}}) begin
        counter_d = counter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= DIR_NONE;
      counter_q   <= '0;
    end else begin
      committed_q <= committed_d;
      counter_q   <= counter_d;
    end
  end

  assign committed_o = committed_q;

endmodule
